FILE: hdl/frame_packet_pacing_scheduler_assert.svh
// assertion macros shared by the scheduler rtl
// expects clk and rst_n in the scope of every use
`ifndef FRAME_PACKET_PACING_SCHEDULER_ASSERT_SVH
`define FRAME_PACKET_PACING_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define FPPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpps same-cycle check failed");

// next-cycle implication
`define FPPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpps next-cycle check failed");

`endif

FILE: hdl/fpps_pkg.sv
// shared constants, types and command/status structs of the pacing scheduler
// no dependencies
package fpps_pkg;

  localparam int PAYLOAD_BYTES    = 1200;
  localparam int FRAME_PERIOD_US  = 16667;
  localparam int PROBES           = 4;
  localparam int MAX_DATA_PACKETS = 56;

  localparam int NS_PER_US   = 1000;
  localparam int RATE_SCALE  = 125000;
  localparam int RATE_DIV    = 3840 * PAYLOAD_BYTES;
  localparam int MULT_ONE    = 256;
  localparam int PROBE_SLOTS = PROBES + 1;

  localparam longint unsigned PERIOD_NS  = 64'(FRAME_PERIOD_US) * 64'(NS_PER_US);
  localparam longint unsigned DATA_NUM   = PERIOD_NS * 64'(MULT_ONE);
  localparam longint unsigned PROBE_NUM0 = DATA_NUM * 64'(PROBE_SLOTS);

  localparam int START_W = 64;
  localparam int RATE_W  = 16;
  localparam int MULT_W  = 10;
  localparam int FRAME_W = 32;
  localparam int PKT_W   = 32;
  localparam int NS_W    = 64;
  localparam int US_W    = 55;

  localparam int IN_TDATA_W  = ((START_W + RATE_W + MULT_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((FRAME_W + PKT_W + NS_W + US_W + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 3;

  localparam int DIV_W      = 64;
  localparam int DIV_STEPS  = DIV_W / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int REM_W      = $clog2(RATE_DIV) + 1;
  localparam int RATE_PROD_W = RATE_W + $clog2(RATE_SCALE);
  localparam int TOT_W      = $clog2(MAX_DATA_PACKETS + 1);
  localparam int IDX_W      = $clog2((MAX_DATA_PACKETS > PROBES) ? MAX_DATA_PACKETS : PROBES);
  localparam int OFF_NS_W   = $clog2(PERIOD_NS + 1);
  localparam int OFF_US_W   = $clog2(FRAME_PERIOD_US + 1);
  localparam int SUB_W      = $clog2(NS_PER_US);
  localparam int PQ_W       = OFF_NS_W + MULT_W;

  // 2^64 = WRAP_US * 1000 + WRAP_SUB
  localparam logic [US_W-1:0]  WRAP_US  = 55'd18446744073709551;
  localparam logic [SUB_W-1:0] WRAP_SUB = 10'd616;

  typedef enum logic [2:0] {
    OP_START,
    OP_TOTAL,
    OP_DQ,
    OP_DQU,
    OP_PO,
    OP_POU,
    OP_PQ,
    OP_PQU
  } fpps_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SUM,
    ST_LOAD
  } fpps_state_t;

  typedef struct packed {
    logic     load_in;
    logic     div_start;
    logic     div_store;
    fpps_op_t op;
    logic     emit_sum;
    logic     emit_load;
    logic     adv_frame;
  } fpps_cmd_t;

  typedef struct packed {
    logic last_pkt;
    logic probe_phase;
    logic out_free;
  } fpps_sts_t;

endpackage

FILE: hdl/fpps_div.sv
// iterative unsigned divider, two quotient bits per cycle
// depends on fpps_pkg
module fpps_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fpps_pkg::DIV_W-1:0]  dividend,
  input  logic [fpps_pkg::REM_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [fpps_pkg::DIV_W-1:0]  quotient,
  output logic [fpps_pkg::REM_W-1:0]  remainder
);
  import fpps_pkg::*;

  logic              busy_r, done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_W-1:0]  dvd_r, dvd_nxt, dvd_mid;
  logic [REM_W-1:0]  rem_r, rem_nxt, rem_mid;
  logic [REM_W-1:0]  dvs_r;
  logic [REM_W:0]    t1, t2, r1, r2;
  logic              ge1, ge2;

  always_comb begin
    t1      = {rem_r, dvd_r[DIV_W-1]};
    ge1     = t1 >= {1'b0, dvs_r};
    r1      = ge1 ? (t1 - {1'b0, dvs_r}) : t1;
    rem_mid = r1[REM_W-1:0];
    dvd_mid = {dvd_r[DIV_W-2:0], ge1};
    t2      = {rem_mid, dvd_mid[DIV_W-1]};
    ge2     = t2 >= {1'b0, dvs_r};
    r2      = ge2 ? (t2 - {1'b0, dvs_r}) : t2;
    rem_nxt = r2[REM_W-1:0];
    dvd_nxt = {dvd_mid[DIV_W-2:0], ge2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

endmodule

FILE: hdl/fpps_ctrl.sv
// sequencer of the pacing scheduler: division steps, data packet emission, more division steps, probe packet emission
// depends on fpps_pkg
module fpps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                div_done,
  input  fpps_pkg::fpps_sts_t sts_i,
  output fpps_pkg::fpps_cmd_t cmd_o
);
  import fpps_pkg::*;

  fpps_state_t state_r, state_nxt;
  fpps_op_t    op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_START;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd_o     = '0;
    cmd_o.op  = op_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.load_in = 1'b1;
          op_nxt        = OP_START;
          state_nxt     = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_nxt       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          cmd_o.div_store = 1'b1;
          state_nxt       = ST_DIV_GO;
          case (op_r)
            OP_START: op_nxt = OP_TOTAL;
            OP_TOTAL: op_nxt = OP_DQ;
            OP_DQ:    op_nxt = OP_DQU;
            OP_PO:    op_nxt = OP_POU;
            OP_POU:   op_nxt = OP_PQ;
            OP_PQ:    op_nxt = OP_PQU;
            default:  state_nxt = ST_SUM;
          endcase
        end
      end
      ST_SUM: begin
        cmd_o.emit_sum = 1'b1;
        state_nxt      = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (!sts_i.last_pkt) begin
            state_nxt = ST_SUM;
          end else if (sts_i.probe_phase) begin
            cmd_o.adv_frame = 1'b1;
            state_nxt       = ST_IDLE;
          end else begin
            op_nxt    = OP_PO;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/fpps_dp.sv
// datapath: request registers, divider operands, offset stepping, output beat
// depends on fpps_pkg; the divider sits beside it in the top level
module fpps_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fpps_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  fpps_pkg::fpps_cmd_t                 cmd_i,
  output fpps_pkg::fpps_sts_t                 sts_o,
  output logic [fpps_pkg::DIV_W-1:0]          div_dvd,
  output logic [fpps_pkg::REM_W-1:0]          div_dvs,
  input  logic [fpps_pkg::DIV_W-1:0]          div_quo,
  input  logic [fpps_pkg::REM_W-1:0]          div_rem,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [fpps_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [fpps_pkg::OUT_TUSER_W-1:0]    out_tuser,
  output logic                                out_tlast
);
  import fpps_pkg::*;

  // request
  logic [START_W-1:0]  start_r;
  logic [RATE_W-1:0]   rate_r;
  logic [MULT_W-1:0]   mult_r;
  logic [MULT_W-1:0]   mult_in;
  // start split into microseconds and leftover ns
  logic [US_W-1:0]     su_r;
  logic [SUB_W-1:0]    sr_r;
  // schedule
  logic [TOT_W-1:0]    total_r;
  logic [REM_W-1:0]    den_r, rq_r, fr_r;
  logic [OFF_NS_W-1:0] tmp_r;
  logic [OFF_US_W-1:0] qu_r, ou_r;
  logic [SUB_W-1:0]    qr_r, or_r;
  logic [IDX_W-1:0]    idx_r;
  logic                probe_r;
  logic [FRAME_W-1:0]  frame_r;
  // launch time sums
  logic [NS_W:0]       ns_sum_r;
  logic [US_W:0]       us_sum_r;
  logic                sub_lt_r;
  // output beat
  logic                out_valid_r;
  logic [FRAME_W-1:0]  out_frame_r;
  logic [PKT_W-1:0]    out_pkt_r;
  logic [NS_W-1:0]     out_ns_r;
  logic [US_W-1:0]     out_us_r;
  logic                out_first_r, out_final_r, out_probe_r, out_end_r;

  logic [RATE_PROD_W-1:0] rate_prod;
  logic [REM_W-1:0]       den_data, den_probe;
  logic [PQ_W-1:0]        pq_num;
  logic [OFF_NS_W-1:0]    off_ns;
  logic [REM_W:0]         fr_sum;
  logic                   fr_carry;
  logic [REM_W-1:0]       fr_nxt;
  logic [SUB_W:0]         or_sum;
  logic                   or_carry;
  logic [SUB_W-1:0]       or_nxt;
  logic [OFF_US_W-1:0]    ou_nxt;
  logic [SUB_W:0]         s_sum;
  logic                   s_carry;
  logic [SUB_W-1:0]       s_sub;
  logic [US_W:0]          us_fix;
  logic                   last_pkt;
  logic [TOT_W-1:0]       total_nxt;

  assign mult_in = in_tdata[START_W+RATE_W +: MULT_W];

  assign rate_prod = RATE_PROD_W'(rate_r) * RATE_PROD_W'(RATE_SCALE);
  assign den_data  = REM_W'(mult_r) * REM_W'(total_r);
  assign den_probe = REM_W'(mult_r) * REM_W'(PROBE_SLOTS);
  assign pq_num    = PQ_W'(PERIOD_NS) * PQ_W'(mult_r - MULT_W'(MULT_ONE));

  // divider operand select
  always_comb begin
    case (cmd_i.op)
      OP_START: begin
        div_dvd = start_r;
        div_dvs = REM_W'(NS_PER_US);
      end
      OP_TOTAL: begin
        div_dvd = DIV_W'(rate_prod);
        div_dvs = REM_W'(RATE_DIV);
      end
      OP_DQ: begin
        div_dvd = DIV_W'(DATA_NUM);
        div_dvs = den_data;
      end
      OP_PO: begin
        div_dvd = DIV_W'(PROBE_NUM0);
        div_dvs = den_probe;
      end
      OP_PQ: begin
        div_dvd = DIV_W'(pq_num);
        div_dvs = den_probe;
      end
      default: begin
        div_dvd = DIV_W'(tmp_r);
        div_dvs = REM_W'(NS_PER_US);
      end
    endcase
  end

  assign total_nxt = (div_quo >= DIV_W'(MAX_DATA_PACKETS - 1)) ? TOT_W'(MAX_DATA_PACKETS)
                                                               : TOT_W'(div_quo) + 1'b1;

  // offset step: whole part plus carry of the fraction, kept as us and ns
  always_comb begin
    fr_sum   = {1'b0, fr_r} + {1'b0, rq_r};
    fr_carry = fr_sum >= {1'b0, den_r};
    fr_nxt   = fr_carry ? REM_W'(fr_sum - {1'b0, den_r}) : fr_sum[REM_W-1:0];
    or_sum   = {1'b0, or_r} + {1'b0, qr_r} + (SUB_W+1)'(fr_carry);
    or_carry = or_sum >= (SUB_W+1)'(NS_PER_US);
    or_nxt   = or_carry ? SUB_W'(or_sum - (SUB_W+1)'(NS_PER_US)) : or_sum[SUB_W-1:0];
    ou_nxt   = ou_r + qu_r + OFF_US_W'(or_carry);
  end

  // start plus offset
  always_comb begin
    off_ns  = OFF_NS_W'(ou_r) * OFF_NS_W'(NS_PER_US) + OFF_NS_W'(or_r);
    s_sum   = {1'b0, sr_r} + {1'b0, or_r};
    s_carry = s_sum >= (SUB_W+1)'(NS_PER_US);
    s_sub   = s_carry ? SUB_W'(s_sum - (SUB_W+1)'(NS_PER_US)) : s_sum[SUB_W-1:0];
  end

  // correct the microsecond count when the ns sum wrapped past 2^64
  assign us_fix = ns_sum_r[NS_W] ? (us_sum_r - (US_W+1)'(WRAP_US) - (US_W+1)'(sub_lt_r))
                                 : us_sum_r;

  assign last_pkt = probe_r ? (idx_r == IDX_W'(PROBES - 1))
                            : (idx_r == IDX_W'(total_r) - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd_i.load_in) begin
      start_r <= in_tdata[START_W-1:0];
      rate_r  <= in_tdata[START_W +: RATE_W];
      mult_r  <= (mult_in < MULT_W'(MULT_ONE)) ? MULT_W'(MULT_ONE) : mult_in;
    end
    if (cmd_i.div_store) begin
      case (cmd_i.op)
        OP_START: begin
          su_r <= div_quo[US_W-1:0];
          sr_r <= div_rem[SUB_W-1:0];
        end
        OP_TOTAL: total_r <= total_nxt;
        OP_DQ: begin
          tmp_r <= div_quo[OFF_NS_W-1:0];
          rq_r  <= div_rem;
          den_r <= den_data;
        end
        OP_DQU: begin
          qu_r    <= div_quo[OFF_US_W-1:0];
          qr_r    <= div_rem[SUB_W-1:0];
          ou_r    <= '0;
          or_r    <= '0;
          fr_r    <= '0;
          idx_r   <= '0;
          probe_r <= 1'b0;
        end
        OP_PO: begin
          tmp_r <= div_quo[OFF_NS_W-1:0];
          fr_r  <= div_rem;
          den_r <= den_probe;
        end
        OP_POU: begin
          ou_r    <= div_quo[OFF_US_W-1:0];
          or_r    <= div_rem[SUB_W-1:0];
          idx_r   <= '0;
          probe_r <= 1'b1;
        end
        OP_PQ: begin
          tmp_r <= div_quo[OFF_NS_W-1:0];
          rq_r  <= div_rem;
        end
        OP_PQU: begin
          qu_r <= div_quo[OFF_US_W-1:0];
          qr_r <= div_rem[SUB_W-1:0];
        end
        default: ;
      endcase
    end
    if (cmd_i.emit_sum) begin
      ns_sum_r <= {1'b0, start_r} + (NS_W+1)'(off_ns);
      us_sum_r <= (US_W+1)'(su_r) + (US_W+1)'(ou_r) + (US_W+1)'(s_carry);
      sub_lt_r <= s_sub < WRAP_SUB;
      ou_r     <= ou_nxt;
      or_r     <= or_nxt;
      fr_r     <= fr_nxt;
    end
    if (cmd_i.emit_load) begin
      idx_r       <= idx_r + 1'b1;
      out_frame_r <= frame_r;
      out_pkt_r   <= probe_r ? ('1 - PKT_W'(idx_r)) : PKT_W'(idx_r);
      out_first_r <= !probe_r && (idx_r == '0);
      out_final_r <= !probe_r && last_pkt;
      out_probe_r <= probe_r;
      out_end_r   <= last_pkt && (probe_r || (PROBES == 0));
      out_ns_r    <= ns_sum_r[NS_W-1:0];
      out_us_r    <= us_fix[US_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      frame_r     <= FRAME_W'(1);
    end else begin
      if (cmd_i.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd_i.adv_frame) begin
        frame_r <= frame_r + 1'b1;
      end
    end
  end

  assign sts_o.last_pkt    = last_pkt;
  assign sts_o.probe_phase = probe_r;
  assign sts_o.out_free    = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_us_r, out_ns_r, out_pkt_r, out_frame_r});
  assign out_tuser  = {out_probe_r, out_final_r, out_first_r};
  assign out_tlast  = out_end_r;

endmodule

FILE: hdl/frame_packet_pacing_scheduler.sv
// Frame packet pacing scheduler, top level.
// Input channel: one beat per frame request (start time, bitrate, pacing multiplier).
// Output channel: one beat per packet, data packets first, then the probe packets;
// tlast marks the last packet of the request and tuser tells data from probe.
// A request runs through eight divisions on one shared divider that retires two
// quotient bits a cycle; four divisions come before the data packets and four
// more before the probe packets. Each packet goes through a sum step for the
// start-plus-offset sums, then a load step that fills the output register.
// A request carries at most 56 data packets and four probes; the divider is the
// pace-setting unit.
// A new request is taken only once every packet of the previous one is loaded;
// the last beat may still be waiting in the output register at that point.
// When the receiver stalls, the output register holds its beat and the sequencer
// waits before loading the next packet; nothing is dropped.
// Reset (synchronous, active low) returns to idle, empties the output register and
// sets the frame counter to one.
// depends on fpps_pkg, fpps_div, fpps_ctrl, fpps_dp and the assertion macro header
`include "frame_packet_pacing_scheduler_assert.svh"

module frame_packet_pacing_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // frame_start_ns, bitrate, pacing_mult
  input  logic [fpps_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // frame_number, packet_number, launch_time_ns, launch_time_us
  output logic [fpps_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // first_flag, final_data_flag, probe_flag
  output logic [fpps_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                              out_tlast
);
  import fpps_pkg::*;

  fpps_cmd_t        cmd;
  fpps_sts_t        sts;
  logic [DIV_W-1:0] div_dvd, div_quo;
  logic [REM_W-1:0] div_dvs, div_rem;
  logic             div_busy, div_done;

  fpps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .div_done  (div_done),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  fpps_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  fpps_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .div_dvd    (div_dvd),
    .div_dvs    (div_dvs),
    .div_quo    (div_quo),
    .div_rem    (div_rem),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  `FPPS_ASSERT_NOW(a_div_start_free, cmd.div_start, !div_busy)
  `FPPS_ASSERT_NOW(a_idle_div_quiet, in_tready, !div_busy && !div_done)
  `FPPS_ASSERT_NEXT(a_one_request, in_tvalid && in_tready, !in_tready)
  `FPPS_ASSERT_NOW(a_last_is_probe, out_tvalid && out_tlast, out_tuser[2])

endmodule

FILE: bench/tb_top.sv
// self-checking bench for frame_packet_pacing_scheduler: requests in, packet beats checked
// against an in-bench schedule predictor, under random idling and long back-pressure
// depends on fpps_pkg and the scheduler rtl
module tb_top;
  import fpps_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 450;
  localparam int EXP_DEPTH = 1024;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] frame_number;
    logic [31:0] packet_number;
    logic        first_flag;
    logic        final_data_flag;
    logic        probe_flag;
    logic [63:0] launch_time_ns;
    logic [54:0] launch_time_us;
    logic        run_end;
  } packet_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic out_tlast;

  // expected packets, written at the tail and read at the head
  packet_t exp_mem [EXP_DEPTH];
  int exp_wr = 0;
  int exp_rd = 0;
  logic [31:0] frame_seq = 32'd1;
  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;
  int cycle_count = 0;

  frame_packet_pacing_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // expected packet schedule of one frame request
  function automatic void schedule_frame(logic [63:0] start, logic [15:0] rate,
                                         logic [9:0] mult_in);
    longint unsigned m, period, byte_budget, total, slots, num, off, k;
    packet_t p;
    m = (mult_in < MULT_ONE) ? 64'(MULT_ONE) : 64'(mult_in);
    period = 64'(FRAME_PERIOD_US) * 64'd1000;
    byte_budget = (64'(rate) * 64'd125000) / 64'd3840;
    total = byte_budget / 64'(PAYLOAD_BYTES) + 64'd1;
    if (total > 64'(MAX_DATA_PACKETS)) total = 64'(MAX_DATA_PACKETS);
    slots = 64'(PROBES) + 64'd1;
    for (k = 0; k < total + 64'(PROBES); k++) begin
      if (k < total) begin
        off = (k * period * 64'd256) / (m * total);
        p.packet_number = 32'(k);
        p.first_flag = (k == 0);
        p.final_data_flag = (k == total - 1);
        p.probe_flag = 1'b0;
      end else begin
        num = period * 64'd256 * slots + (k - total) * (period * m - period * 64'd256);
        off = num / (m * slots);
        p.packet_number = 32'hFFFF_FFFF - 32'(k - total);
        p.first_flag = 1'b0;
        p.final_data_flag = 1'b0;
        p.probe_flag = 1'b1;
      end
      p.frame_number = frame_seq;
      p.launch_time_ns = start + off;
      p.launch_time_us = 55'(p.launch_time_ns / 64'd1000);
      p.run_end = (k == total + 64'(PROBES) - 1);
      exp_mem[exp_wr % EXP_DEPTH] = p;
      exp_wr++;
    end
    frame_seq = frame_seq + 32'd1;
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // receiver: random idling plus an occasional long hold-off
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    packet_t p;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected packet beat: frame %0d packet %0d", out_tdata[31:0],
               out_tdata[63:32]);
        mismatches++;
      end else begin
        p = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        check_field("frame_number", 64'(p.frame_number), 64'(out_tdata[31:0]));
        check_field("packet_number", 64'(p.packet_number), 64'(out_tdata[63:32]));
        check_field("first_flag", 64'(p.first_flag), 64'(out_tuser[0]));
        check_field("final_data_flag", 64'(p.final_data_flag), 64'(out_tuser[1]));
        check_field("probe_flag", 64'(p.probe_flag), 64'(out_tuser[2]));
        check_field("launch_time_ns", p.launch_time_ns, out_tdata[127:64]);
        check_field("launch_time_us", 64'(p.launch_time_us), 64'(out_tdata[182:128]));
        check_field("run_end", 64'(p.run_end), 64'(out_tlast));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // called at a falling edge, returns at a falling edge with the beat accepted
  task automatic send_request(logic [63:0] start, logic [15:0] rate, logic [9:0] mult);
    if (tx_idle_pct != 0 && $urandom_range(99) < 5) begin
      repeat ($urandom_range(20, 450)) begin
        in_tvalid = 1'b0;
        @(negedge clk);
      end
    end
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {6'b0, mult, rate, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    schedule_frame(start, rate, mult);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_tvalid = 1'b0;
    while (exp_rd != exp_wr) @(negedge clk);
  endtask

  task automatic test_directed();
    send_request(64'd0, 16'd0, 10'd256);
    send_request(ALL_ONES, 16'd0, 10'd0);
    send_request(ALL_ONES - 64'd999, 16'hFFFF, 10'h3FF);
    send_request(ALL_ONES - 64'd8_000_000, 16'd1000, 10'd320);
    send_request(64'd123_456_789, 16'd36, 10'd320);
    send_request(64'd123_456_789, 16'd37, 10'd320);
    send_request(64'd5_000_000_000, 16'd2027, 10'd320);
    send_request(64'd5_000_000_000, 16'd2028, 10'd320);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 16'h5555, 10'h2AA);
    send_request(64'h5555_5555_5555_5555, 16'hAAAA, 10'h155);
    send_request(64'd1_000_000, 16'd500, 10'd255);
    send_request(64'd1_000_000, 16'd500, 10'd1);
    send_request(64'd1_000_000, 16'd500, 10'd257);
    send_request(64'd1_000_000, 16'd0, 10'h3FF);
    send_request(64'h8000_0000_0000_0000, 16'd1200, 10'd512);
    send_request(ALL_ONES - 64'd16_000_000, 16'd300, 10'd256);
  endtask

  task automatic send_random_request(bit heavy);
    logic [63:0] start;
    logic [15:0] rate;
    logic [9:0] mult;
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) start = {$urandom, $urandom};
    else if (pick < 85) start = ALL_ONES - 64'($urandom_range(0, 20_000_000));
    else start = 64'($urandom);
    pick = $urandom_range(99);
    if (heavy || pick < 20) rate = 16'($urandom);
    else if (pick < 50) rate = 16'($urandom_range(0, 200));
    else rate = 16'($urandom_range(0, 2100));
    pick = $urandom_range(99);
    if (pick < 75) mult = 10'($urandom_range(256, 1023));
    else if (pick < 87) mult = 10'($urandom_range(0, 255));
    else mult = (pick < 93) ? 10'd256 : 10'h3FF;
    send_request(start, rate, mult);
  endtask

  task automatic test_random_traffic(int count);
    repeat (count) send_random_request(1'b0);
  endtask

  // receiver stalls long enough that the block backs up into its input
  task automatic test_output_backpressure();
    @(posedge clk);
    rx_hold_left = 3000;
    @(negedge clk);
    repeat (6) send_random_request(1'b1);
  endtask

  task automatic test_drain_pause();
    repeat (3) send_random_request(1'b0);
    wait_for_drain();
    repeat (3) send_random_request(1'b0);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    tx_idle_pct = 10;
    rx_idle_pct = 65;
    test_directed();
    test_random_traffic(85);
    test_output_backpressure();
    test_drain_pause();

    tx_idle_pct = 65;
    rx_idle_pct = 10;
    test_random_traffic(85);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(85);

    in_tvalid = 1'b0;
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: frame_packet_pacing_scheduler.f
+incdir+hdl
hdl/fpps_pkg.sv
hdl/fpps_div.sv
hdl/fpps_ctrl.sv
hdl/fpps_dp.sv
hdl/frame_packet_pacing_scheduler.sv
bench/tb_top.sv
